/* rtl/core/pcm_pkg.sv */
// Package for the Pearson correlation matrix block.
// Holds the command codes, state types and fixed field widths; no dependencies.
package pcm_pkg;

   localparam int CMD_W    = 2;
   localparam int FIDX_W   = 5;
   localparam int SAMPLE_W = 16;
   localparam int MEAN_W   = 24;
   localparam int COEF_W   = 16;
   localparam int SUM_W    = 64;
   localparam int DEV_W    = 25;            // sample*256 - mean, signed
   localparam int PROD_W   = 2 * DEV_W;     // product of two deviations
   localparam int WIDE_W   = 2 * SUM_W;     // diagonal product
   localparam int REM_W    = SUM_W + 3;     // square root remainder

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_MEAN   = 2'd0,
      CMD_LOAD_SAMPLE = 2'd1,
      CMD_QUERY       = 2'd2,
      CMD_CLEAR       = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROW,
      ST_DEVI,
      ST_SWEEP,
      ST_DRAIN,
      ST_QRD0,
      ST_QRD1,
      ST_QRD2,
      ST_QRD3,
      ST_QRD4,
      ST_QRUN,
      ST_QBAD
   } state_type;

   typedef enum logic [2:0] {
      Q_IDLE,
      Q_MUL,
      Q_CHK,
      Q_SQRT,
      Q_DIV,
      Q_DONE
   } qstate_type;

endpackage

/* rtl/core/pcm_if.sv */
// Valid/ready channel interfaces for the request and response sides.
// Depends on pcm_pkg for field widths.
interface pcm_req_if;
   logic                               valid;
   logic                               ready;
   logic [pcm_pkg::CMD_W-1:0]          command;
   logic [pcm_pkg::FIDX_W-1:0]         feature_index;
   logic [pcm_pkg::FIDX_W-1:0]         column_index;
   logic [pcm_pkg::SAMPLE_W-1:0]       sample_value;
   logic [pcm_pkg::MEAN_W-1:0]         mean_value;

   modport source (output valid, command, feature_index, column_index, sample_value,
                   mean_value, input ready);
   modport sink   (input valid, command, feature_index, column_index, sample_value,
                   mean_value, output ready);
endinterface

interface pcm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [pcm_pkg::COEF_W-1:0]  coefficient;
   logic                               degenerate;

   modport source (output valid, coefficient, degenerate, input ready);
   modport sink   (input valid, coefficient, degenerate, output ready);
endinterface

/* rtl/core/pcm_qdiv.sv */
// Iterative coefficient unit: diagonal product, square root and Q1.15 divide.
// Depends on pcm_pkg.
module pcm_qdiv (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [pcm_pkg::SUM_W-1:0]         sij,
   input  logic [pcm_pkg::SUM_W-1:0]         sii,
   input  logic [pcm_pkg::SUM_W-1:0]         sjj,
   input  logic                              ack,
   output logic                              done,
   output logic signed [pcm_pkg::COEF_W-1:0] coefficient,
   output logic                              degenerate
);
   import pcm_pkg::*;

   qstate_type          state_ff, state_in;
   logic [SUM_W-1:0]    a_ff, a_in, b_ff, b_in;
   logic [SUM_W-1:0]    mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [WIDE_W-1:0]   acc_ff, acc_in;
   logic [SUM_W-1:0]    pp_ff, pp_in;
   logic [1:0]          ppk_ff, ppk_in;
   logic [6:0]          cnt_ff, cnt_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]    root_ff, root_in;
   logic [15:0]         q_ff, q_in;
   logic                full_ff, full_in;
   logic                degen_ff, degen_in;

   logic [31:0]         a_part, b_part;
   logic [1:0]          sh_sum;
   logic [WIDE_W-1:0]   pp_shift;
   logic [REM_W-1:0]    rem_sh, trial;
   logic [SUM_W:0]      dv_sh;
   logic [16:0]         q_round;
   logic [15:0]         q_mag;

   // partial products and square-root / divide steps
   always_comb begin
      a_part   = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_part   = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp_in    = {32'd0, a_part} * {32'd0, b_part};
      sh_sum   = {1'b0, ppk_ff[1]} + {1'b0, ppk_ff[0]};
      pp_shift = {{SUM_W{1'b0}}, pp_ff} << {sh_sum, 5'd0};
      rem_sh   = {rem_ff[REM_W-3:0], acc_ff[WIDE_W-1 -: 2]};
      trial    = {1'b0, root_ff, 2'b01};
      dv_sh    = {rem_ff[SUM_W-1:0], 1'b0};
      q_round  = ({1'b0, q_ff} + 17'd1) >> 1;
      q_mag    = full_ff ? 16'h8000 : q_round[15:0];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      ppk_in   = ppk_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      q_in     = q_ff;
      full_in  = full_ff;
      degen_in = degen_ff;
      case (state_ff)
         Q_IDLE: begin
            if (start) begin
               a_in     = sii;
               b_in     = sjj;
               neg_in   = sij[SUM_W-1];
               mag_in   = sij[SUM_W-1] ? (~sij + 64'd1) : sij;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = Q_MUL;
            end
         end
         Q_MUL: begin
            if (cnt_ff != 7'd0) begin
               acc_in = acc_ff + pp_shift;
            end
            ppk_in = cnt_ff[1:0];
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd4) begin
               state_in = Q_CHK;
            end
         end
         Q_CHK: begin
            rem_in  = '0;
            root_in = '0;
            cnt_in  = '0;
            if (acc_ff == '0) begin
               degen_in = 1'b1;
               state_in = Q_DONE;
            end else begin
               state_in = Q_SQRT;
            end
         end
         Q_SQRT: begin
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[SUM_W-2:0], 1'b0};
            end
            acc_in = acc_ff << 2;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               cnt_in   = '0;
               state_in = Q_DIV;
            end
         end
         Q_DIV: begin
            // first cycle loads the magnitude; full scale skips the divide
            if (cnt_ff == 7'd0) begin
               degen_in = 1'b0;
               q_in     = '0;
               rem_in   = {3'd0, mag_ff};
               full_in  = (mag_ff >= root_ff);
               cnt_in   = 7'd1;
               if (mag_ff >= root_ff) begin
                  state_in = Q_DONE;
               end
            end else begin
               if (dv_sh >= {1'b0, root_ff}) begin
                  rem_in = {2'd0, dv_sh - {1'b0, root_ff}};
                  q_in   = {q_ff[14:0], 1'b1};
               end else begin
                  rem_in = {2'd0, dv_sh};
                  q_in   = {q_ff[14:0], 1'b0};
               end
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff == 7'd16) begin
                  state_in = Q_DONE;
               end
            end
         end
         Q_DONE: begin
            if (ack) begin
               state_in = Q_IDLE;
            end
         end
         default: state_in = Q_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Q_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      acc_ff   <= acc_in;
      pp_ff    <= pp_in;
      ppk_ff   <= ppk_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      q_ff     <= q_in;
      full_ff  <= full_in;
      degen_ff <= degen_in;
   end

   // sign and saturation
   always_comb begin
      done       = (state_ff == Q_DONE);
      degenerate = degen_ff;
      if (degen_ff) begin
         coefficient = '0;
      end else if (neg_ff) begin
         coefficient = -$signed(q_mag);
      end else begin
         coefficient = (q_mag > 16'd32767) ? 16'sd32767 : $signed(q_mag);
      end
   end

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == Q_IDLE) else $error("start while unit busy");
   a_ack_done: assert property (@(posedge clock) disable iff (reset)
      ack |-> state_ff == Q_DONE) else $error("ack without result");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      done && degenerate |-> coefficient == 16'sd0) else $error("degenerate nonzero");
`endif
endmodule

/* rtl/core/pearson_correlation_matrix_top.sv */
// Pearson correlation matrix: command sequencer, mean/row/pair-sum memories
// and the row accumulation pipeline. Depends on pcm_pkg, pcm_if, pcm_qdiv.
//
// The sample for the last feature, unless MAX_ROWS rows are already in,
// starts a read-modify-write sweep through the pair-sum memory, one entry
// per cycle apart from the row and deviation steps before each row, and no
// request is taken until the sweep ends. A query with valid indices reads
// three pair sums in states QRD0 to QRD4 and runs the coefficient unit: a
// multiply of four partial products, one zero check, 64 square-root steps
// and a divide, which a full-scale result skips. A clear, and the clearing
// pass after reset, zero every pair-sum entry, and no request is taken
// until the pass ends. A finished response waits in an output register
// and does not block the next request.
module pearson_correlation_matrix_top #(
   parameter int FEATURES = 30,
   parameter int MAX_ROWS = 4096
) (
   input  logic       clock,
   input  logic       reset,
   pcm_req_if.sink    req_ch,
   pcm_rsp_if.source  rsp_ch
);
   import pcm_pkg::*;

   localparam int DEPTH  = FEATURES * FEATURES;
   localparam int IDX_W  = $clog2(FEATURES);
   localparam int PS_W   = $clog2(DEPTH);
   localparam int ROWS_W = $clog2(MAX_ROWS + 1);

   // memories
   logic [MEAN_W-1:0]   mean_mem [FEATURES];
   logic [SAMPLE_W-1:0] row_mem  [FEATURES];
   logic [SUM_W-1:0]    ps_mem   [DEPTH];

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    i_ff, i_in, j_ff, j_in;
   logic [PS_W-1:0]     addr_ff, addr_in;
   logic [ROWS_W-1:0]   rows_ff, rows_in;
   logic signed [DEV_W-1:0] devi_ff, devi_in;
   logic [SUM_W-1:0]    sij_ff, sij_in, sii_ff, sii_in;

   logic                s1_ff, s1_in, s2_ff;
   logic [PS_W-1:0]     a1_ff, a2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [SUM_W-1:0]    sum_ff;

   logic [IDX_W-1:0]    fr_addr;
   logic [MEAN_W-1:0]   mean_q_ff;
   logic [SAMPLE_W-1:0] row_q_ff;
   logic [PS_W-1:0]     ps_raddr, ps_waddr;
   logic [SUM_W-1:0]    ps_q_ff, ps_wdata;
   logic                ps_we;

   logic                req_fire, idx_ok, q_ok;
   cmd_type             cmd;
   logic signed [DEV_W-1:0] devj;

   logic                q_start, q_ack, q_done, q_degen;
   logic signed [COEF_W-1:0] q_coef;
   logic                rsp_free, rsp_load;
   logic signed [COEF_W-1:0] coef_in;
   logic                degen_in;
   logic                rsp_valid_ff;
   logic signed [COEF_W-1:0] coef_ff;
   logic                degen_ff;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign cmd      = cmd_type'(req_ch.command);
   assign idx_ok   = (int'(req_ch.feature_index) < FEATURES);
   assign q_ok     = idx_ok && (int'(req_ch.column_index) < FEATURES);
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign devj     = $signed({1'b0, row_q_ff, 8'd0}) - $signed({1'b0, mean_q_ff});

   // sequencer
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      addr_in  = addr_ff;
      rows_in  = rows_ff;
      devi_in  = devi_ff;
      sij_in   = sij_ff;
      sii_in   = sii_ff;
      s1_in    = 1'b0;
      fr_addr  = j_ff;
      ps_raddr = addr_ff;
      q_start  = 1'b0;
      q_ack    = 1'b0;
      rsp_load = 1'b0;
      coef_in  = q_coef;
      degen_in = q_degen;
      req_ch.ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + PS_W'(1);
            if (addr_ff == PS_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_fire) begin
               case (cmd)
                  CMD_LOAD_SAMPLE: begin
                     if (idx_ok && int'(req_ch.feature_index) == FEATURES - 1 &&
                         int'(rows_ff) < MAX_ROWS) begin
                        rows_in  = rows_ff + ROWS_W'(1);
                        i_in     = '0;
                        j_in     = '0;
                        addr_in  = '0;
                        state_in = ST_ROW;
                     end
                  end
                  CMD_QUERY: begin
                     i_in     = IDX_W'(req_ch.feature_index);
                     j_in     = IDX_W'(req_ch.column_index);
                     state_in = q_ok ? ST_QRD0 : ST_QBAD;
                  end
                  CMD_CLEAR: begin
                     rows_in  = '0;
                     addr_in  = '0;
                     state_in = ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         ST_ROW: begin
            fr_addr  = i_ff;
            state_in = ST_DEVI;
         end
         ST_DEVI: begin
            devi_in  = devj;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            s1_in   = 1'b1;
            addr_in = addr_ff + PS_W'(1);
            j_in    = j_ff + IDX_W'(1);
            if (int'(j_ff) == FEATURES - 1) begin
               j_in = '0;
               if (int'(i_ff) == FEATURES - 1) begin
                  state_in = ST_DRAIN;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = ST_ROW;
               end
            end
         end
         ST_DRAIN: begin
            if (!s1_ff && !s2_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_QRD0: begin
            ps_raddr = PS_W'(i_ff) * PS_W'(FEATURES) + PS_W'(j_ff);
            state_in = ST_QRD1;
         end
         ST_QRD1: begin
            ps_raddr = PS_W'(i_ff) * PS_W'(FEATURES + 1);
            sij_in   = ps_q_ff;
            state_in = ST_QRD2;
         end
         ST_QRD2: begin
            ps_raddr = PS_W'(j_ff) * PS_W'(FEATURES + 1);
            sii_in   = ps_q_ff;
            state_in = ST_QRD3;
         end
         ST_QRD3: begin
            // hold the diagonal read so the unit sees it at start
            ps_raddr = PS_W'(j_ff) * PS_W'(FEATURES + 1);
            state_in = ST_QRD4;
         end
         ST_QRD4: begin
            q_start  = 1'b1;
            state_in = ST_QRUN;
         end
         ST_QRUN: begin
            if (q_done && rsp_free) begin
               q_ack    = 1'b1;
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_QBAD: begin
            coef_in  = '0;
            degen_in = 1'b1;
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
         rows_ff  <= '0;
         s1_ff    <= 1'b0;
         s2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         rows_ff  <= rows_in;
         s1_ff    <= s1_in;
         s2_ff    <= s1_ff;
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      devi_ff <= devi_in;
      sij_ff  <= sij_in;
      sii_ff  <= sii_in;
      a1_ff   <= addr_ff;
      a2_ff   <= a1_ff;
      prod_ff <= devi_ff * devj;
      sum_ff  <= ps_q_ff;
   end

   // mean and row buffer memories
   always_ff @(posedge clock) begin
      if (req_fire && idx_ok && cmd == CMD_LOAD_MEAN) begin
         mean_mem[IDX_W'(req_ch.feature_index)] <= req_ch.mean_value;
      end
      if (req_fire && idx_ok && cmd == CMD_LOAD_SAMPLE) begin
         row_mem[IDX_W'(req_ch.feature_index)] <= req_ch.sample_value;
      end
      mean_q_ff <= mean_mem[fr_addr];
      row_q_ff  <= row_mem[fr_addr];
   end

   // pair-sum memory: clearing pass or accumulate write-back
   always_comb begin
      ps_we    = (state_ff == ST_CLEAR) || s2_ff;
      ps_waddr = (state_ff == ST_CLEAR) ? addr_ff : a2_ff;
      ps_wdata = (state_ff == ST_CLEAR) ? '0
                 : sum_ff + SUM_W'(unsigned'({{(SUM_W-PROD_W){prod_ff[PROD_W-1]}},
                                              prod_ff}));
   end

   always_ff @(posedge clock) begin
      if (ps_we) begin
         ps_mem[ps_waddr] <= ps_wdata;
      end
      ps_q_ff <= ps_mem[ps_raddr];
   end

   pcm_qdiv u_qdiv (
      .clock       (clock),
      .reset       (reset),
      .start       (q_start),
      .sij         (sij_ff),
      .sii         (sii_ff),
      .sjj         (ps_q_ff),
      .ack         (q_ack),
      .done        (q_done),
      .coefficient (q_coef),
      .degenerate  (q_degen)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         coef_ff  <= coef_in;
         degen_ff <= degen_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.coefficient = coef_ff;
   assign rsp_ch.degenerate  = degen_ff;

`ifndef SYNTH
   a_no_wb_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !s2_ff) else $error("write-back during clearing pass");
   a_no_wb_in_query: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QRD0 || state_ff == ST_QRD1 || state_ff == ST_QRD2)
      |-> !s1_ff && !s2_ff) else $error("query read overlaps accumulation");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rsp_free) else $error("response overwritten");
   a_waddr_range: assert property (@(posedge clock) disable iff (reset)
      ps_we |-> int'(ps_waddr) < DEPTH) else $error("pair-sum address out of range");
`endif
endmodule
